// ===== rtl/core/sse_pkg.sv =====
// Shared constants, types and arithmetic helpers for the state-space Euler step block.
package sse_pkg;

  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W     = $clog2(MAX_ORDER + 1);
  localparam int BANK_W    = 2;
  localparam int CADDR_W   = BANK_W + IDX_W;
  localparam int CF_DEPTH  = 1 << CADDR_W;

  localparam int Q_W        = 32;
  localparam int DT_W       = 17;
  localparam int ORD_W      = 4;
  localparam int CIDX_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Accumulators hold up to MAX_ORDER+1 products of 49 bits after the shift.
  localparam int ACC_W = 49 + CNT_W;
  localparam int DER_W = ACC_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ORDER = CFG_IDX_W'(1);

  localparam logic [DT_W-1:0]  TIME_STEP_RESET    = DT_W'(655);
  localparam logic [ORD_W-1:0] ACTIVE_ORDER_RESET = ORD_W'(8);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [BANK_W-1:0] BANK_A = 2'd0;
  localparam logic [BANK_W-1:0] BANK_B = 2'd1;
  localparam logic [BANK_W-1:0] BANK_C = 2'd2;
  localparam logic [BANK_W-1:0] BANK_D = 2'd3;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  // Control word that travels down the datapath pipeline with each issued step.
  typedef struct packed {
    logic             valid;
    logic             upd;
    logic             is_d;
    logic             last;
    logic             use_fb;
    logic [IDX_W-1:0] idx;
  } sse_stage_t;

  typedef struct packed {
    logic [Q_W-1:0] value;
    logic           clip;
  } sse_sat_t;

  function automatic sse_sat_t sat_q(input logic signed [DER_W-1:0] v);
    sse_sat_t            r;
    logic [DER_W-32:0]   hi_bits;
    hi_bits = v[DER_W-1:31];
    if ((&hi_bits) || !(|hi_bits)) begin
      r.value = v[Q_W-1:0];
      r.clip  = 1'b0;
    end else begin
      r.value = v[DER_W-1] ? Q_MIN : Q_MAX;
      r.clip  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] order_in_use(input logic [ORD_W-1:0] ord);
    logic [CNT_W-1:0] n;
    if (ord == '0) begin
      n = CNT_W'(1);
    end else if (int'(ord) > MAX_ORDER) begin
      n = CNT_W'(MAX_ORDER);
    end else begin
      n = CNT_W'(ord);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/sse_if.sv =====
// Request and response channel interfaces of the state-space Euler step block.
interface sse_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [sse_pkg::BANK_W-1:0] coef_bank;
  logic [sse_pkg::CIDX_W-1:0] coef_index;
  logic signed [sse_pkg::Q_W-1:0] coef_value;
  logic signed [sse_pkg::Q_W-1:0] sample_value;

  modport source(output valid, req_type, coef_bank, coef_index, coef_value, sample_value,
                 input ready);
  modport sink(input valid, req_type, coef_bank, coef_index, coef_value, sample_value,
               output ready);
endinterface

interface sse_rsp_if;
  logic                           valid;
  logic                           ready;
  logic signed [sse_pkg::Q_W-1:0] response_value;
  logic                           saturated;

  modport source(output valid, response_value, saturated, input ready);
  modport sink(input valid, response_value, saturated, output ready);
endinterface

// ===== rtl/core/sse_state_mem.sv =====
// State vector memory: one write port, two registered read ports, per-entry valid bits.
module sse_state_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [sse_pkg::IDX_W-1:0]   waddr,
  input  logic [sse_pkg::Q_W-1:0]     wdata,
  input  logic [sse_pkg::IDX_W-1:0]   raddr_a,
  input  logic [sse_pkg::IDX_W-1:0]   raddr_b,
  output logic [sse_pkg::Q_W-1:0]     rdata_a,
  output logic [sse_pkg::Q_W-1:0]     rdata_b
);

  logic [sse_pkg::Q_W-1:0]       mem [sse_pkg::MAX_ORDER];
  logic [sse_pkg::MAX_ORDER-1:0] vld_r;
  logic [sse_pkg::Q_W-1:0]       rd_a_r;
  logic [sse_pkg::Q_W-1:0]       rd_b_r;
  logic                          rvld_a_r;
  logic                          rvld_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvld_a_r <= 1'b0;
      rvld_b_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_a_r <= vld_r[raddr_a];
      rvld_b_r <= vld_r[raddr_b];
    end
  end

  assign rdata_a = rvld_a_r ? rd_a_r : '0;
  assign rdata_b = rvld_b_r ? rd_b_r : '0;

endmodule

// ===== rtl/core/sse_coef_mem.sv =====
// Coefficient memory for the a, b, c banks and d: one write port, two registered reads.
module sse_coef_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [sse_pkg::CADDR_W-1:0] waddr,
  input  logic [sse_pkg::Q_W-1:0]     wdata,
  input  logic [sse_pkg::CADDR_W-1:0] raddr_a,
  input  logic [sse_pkg::CADDR_W-1:0] raddr_b,
  output logic [sse_pkg::Q_W-1:0]     rdata_a,
  output logic [sse_pkg::Q_W-1:0]     rdata_b
);

  logic [sse_pkg::Q_W-1:0]      mem [sse_pkg::CF_DEPTH];
  logic [sse_pkg::CF_DEPTH-1:0] vld_r;
  logic [sse_pkg::Q_W-1:0]      rd_a_r;
  logic [sse_pkg::Q_W-1:0]      rd_b_r;
  logic                         rvld_a_r;
  logic                         rvld_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvld_a_r <= 1'b0;
      rvld_b_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_a_r <= vld_r[raddr_a];
      rvld_b_r <= vld_r[raddr_b];
    end
  end

  assign rdata_a = rvld_a_r ? rd_a_r : '0;
  assign rdata_b = rvld_b_r ? rd_b_r : '0;

endmodule

// ===== rtl/core/sse_dp.sv =====
// Datapath: two shared multipliers, output and feedback accumulators, Euler update.
module sse_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sse_pkg::sse_stage_t              issue,
  input  logic                             start,
  input  logic signed [sse_pkg::Q_W-1:0]   sample_value,
  input  logic [sse_pkg::DT_W-1:0]         time_step,
  input  logic signed [sse_pkg::Q_W-1:0]   st_rd_a,
  input  logic signed [sse_pkg::Q_W-1:0]   st_rd_b,
  input  logic signed [sse_pkg::Q_W-1:0]   cf_rd_a,
  input  logic signed [sse_pkg::Q_W-1:0]   cf_rd_b,
  output logic                             st_we,
  output logic [sse_pkg::IDX_W-1:0]        st_waddr,
  output logic [sse_pkg::Q_W-1:0]          st_wdata,
  output logic                             wb_done,
  output logic [sse_pkg::Q_W-1:0]          rsp_value,
  output logic                             rsp_sat
);

  localparam int ACC_W = sse_pkg::ACC_W;
  localparam int DER_W = sse_pkg::DER_W;

  sse_pkg::sse_stage_t c1_r, c2_r, c3_r, c4_r;

  logic signed [31:0]      u_r;
  logic signed [31:0]      x_s2_r, x_s3_r, x_s4_r, xn_s2_r;
  logic signed [63:0]      p1_r;
  logic signed [64:0]      p2_r;
  logic signed [ACC_W-1:0] acc_y_r, acc_f_r;
  logic signed [31:0]      deriv_r;
  logic                    clip_r;

  logic signed [31:0]      m1_a, m1_b;
  logic signed [63:0]      m1_p;
  logic signed [32:0]      m2_a;
  logic signed [31:0]      m2_b;
  logic signed [64:0]      m2_p;
  logic                    p2_en;
  logic signed [DER_W-1:0] deriv_raw, nx_raw;
  sse_pkg::sse_sat_t       deriv_s, nx_s, y_s;

  // Multiplier one: c*x or d*u while summing, b*u while updating.
  assign m1_a = cf_rd_a;
  assign m1_b = (c1_r.is_d || c1_r.upd) ? u_r : st_rd_a;
  assign m1_p = m1_a * m1_b;

  // Multiplier two: (-a)*x while summing, deriv*dt three stages into an update step.
  always_comb begin
    if (c3_r.valid && c3_r.upd) begin
      m2_a = {deriv_r[31], deriv_r};
      m2_b = {{(32 - sse_pkg::DT_W){1'b0}}, time_step};
    end else begin
      m2_a = c1_r.is_d ? 33'sd0 : (33'sd0 - {cf_rd_b[31], cf_rd_b});
      m2_b = st_rd_a;
    end
  end
  assign m2_p  = m2_a * m2_b;
  assign p2_en = (c1_r.valid && !c1_r.upd) || (c3_r.valid && c3_r.upd);

  assign deriv_raw = DER_W'($signed(p1_r[63:16]))
                   + (c2_r.use_fb ? DER_W'(acc_f_r) : DER_W'(xn_s2_r));
  assign deriv_s   = sse_pkg::sat_q(deriv_raw);
  assign nx_raw    = DER_W'(x_s4_r) + DER_W'($signed(p2_r[64:16]));
  assign nx_s      = sse_pkg::sat_q(nx_raw);
  assign y_s       = sse_pkg::sat_q(DER_W'(acc_y_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else begin
      c1_r <= issue;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u_r <= sample_value;
    end
    if (c1_r.valid) begin
      p1_r    <= m1_p;
      x_s2_r  <= st_rd_a;
      xn_s2_r <= st_rd_b;
    end
    if (p2_en) begin
      p2_r <= m2_p;
    end
    x_s3_r <= x_s2_r;
    x_s4_r <= x_s3_r;

    if (start) begin
      acc_y_r <= '0;
      acc_f_r <= '0;
    end else if (c2_r.valid && !c2_r.upd) begin
      acc_y_r <= acc_y_r + ACC_W'($signed(p1_r[63:16]));
      acc_f_r <= acc_f_r + ACC_W'($signed(p2_r[64:16]));
    end

    if (c2_r.valid && c2_r.upd) begin
      deriv_r <= $signed(deriv_s.value);
    end

    if (start) begin
      clip_r <= 1'b0;
    end else begin
      clip_r <= clip_r | (c2_r.valid && c2_r.upd && deriv_s.clip)
                       | (c4_r.valid && c4_r.upd && nx_s.clip);
    end
  end

  assign st_we     = c4_r.valid && c4_r.upd;
  assign st_waddr  = c4_r.idx;
  assign st_wdata  = nx_s.value;
  assign wb_done   = st_we && c4_r.last;
  assign rsp_value = y_s.value;
  assign rsp_sat   = clip_r | y_s.clip;

endmodule

// ===== rtl/core/sse_seq.sv =====
// Sequencer: walks the state and coefficient memories for the sums and the update.
module sse_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sse_pkg::CNT_W-1:0]   n_i,
  input  logic                        wb_done,
  input  logic                        out_free,
  output logic                        idle,
  output sse_pkg::sse_stage_t         issue,
  output logic [sse_pkg::IDX_W-1:0]   st_raddr_a,
  output logic [sse_pkg::IDX_W-1:0]   st_raddr_b,
  output logic [sse_pkg::CADDR_W-1:0] cf_raddr_a,
  output logic [sse_pkg::CADDR_W-1:0] cf_raddr_b,
  output logic                        load_out
);

  localparam int CNT_W = sse_pkg::CNT_W;
  localparam int IDX_W = sse_pkg::IDX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] nm1, rev, inc;
  logic [IDX_W-1:0] idx;
  logic             is_d, is_fb;

  assign nm1   = n_i - CNT_W'(1);
  assign rev   = nm1 - cnt_r;
  assign inc   = cnt_r + CNT_W'(1);
  assign idx   = cnt_r[IDX_W-1:0];
  assign is_d  = (cnt_r == n_i);
  assign is_fb = (cnt_r == nm1);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    issue      = '0;
    st_raddr_a = '0;
    st_raddr_b = '0;
    cf_raddr_a = '0;
    cf_raddr_b = '0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      // One step per state entry, then a final step that brings in d*u.
      ST_SUM: begin
        issue.valid = 1'b1;
        issue.is_d  = is_d;
        issue.last  = is_d;
        issue.idx   = idx;
        st_raddr_a  = is_d ? '0 : idx;
        cf_raddr_a  = is_d ? {sse_pkg::BANK_D, IDX_W'(0)} : {sse_pkg::BANK_C, idx};
        cf_raddr_b  = {sse_pkg::BANK_A, rev[IDX_W-1:0]};
        if (is_d) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = inc;
        end
      end
      // Row i reads x[i] and x[i+1]; x[i] is written back only after both reads of it.
      ST_UPD: begin
        issue.valid  = 1'b1;
        issue.upd    = 1'b1;
        issue.use_fb = is_fb;
        issue.last   = is_fb;
        issue.idx    = idx;
        st_raddr_a   = idx;
        st_raddr_b   = is_fb ? '0 : inc[IDX_W-1:0];
        cf_raddr_a   = {sse_pkg::BANK_B, idx};
        if (is_fb) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = inc;
        end
      end
      ST_DRAIN: begin
        if (wb_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == ST_IDLE)
    else $error("sample started while the sequencer was busy");
  a_wb_drain: assert property (@(posedge clk) disable iff (!rst_n)
    wb_done |-> state_r == ST_DRAIN)
    else $error("last state write-back outside the drain phase");
  a_wb_done: assert property (@(posedge clk) disable iff (!rst_n)
    wb_done |=> state_r == ST_DONE)
    else $error("result stage not entered after the last write-back");
`endif

endmodule

// ===== rtl/core/state_space_euler_step.sv =====
// Load item: accepted while idle; the block stays idle and ready after a load.
// Sample item: the result is set by two passes of the shared multiply pipeline over the
// state memory, one for the sums, one for the update.
// A new item is taken only once the last result is in the output register, where it waits.
// Reset restores time_step and active_order and makes every state and coefficient entry
// read as zero through per-entry valid bits, with no clearing pass.
module state_space_euler_step (
  input  logic                           clk,
  input  logic                           rst_n,
  sse_req_if.sink                        in_req,
  sse_rsp_if.source                      out_rsp,
  input  logic                           cfg_we,
  input  logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sse_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [sse_pkg::DT_W-1:0]    time_step_r;
  logic [sse_pkg::ORD_W-1:0]   active_order_r;
  logic [sse_pkg::CNT_W-1:0]   order_n;

  logic                        accept, load, start;
  logic                        idle, load_out, out_free, wb_done;
  sse_pkg::sse_stage_t         issue;
  logic [sse_pkg::IDX_W-1:0]   st_raddr_a, st_raddr_b, st_waddr;
  logic [sse_pkg::CADDR_W-1:0] cf_raddr_a, cf_raddr_b, cf_waddr;
  logic [sse_pkg::Q_W-1:0]     st_rd_a, st_rd_b, cf_rd_a, cf_rd_b, st_wdata;
  logic                        st_we, cf_we;
  logic [sse_pkg::Q_W-1:0]     rsp_value;
  logic                        rsp_sat;

  logic                        out_valid_r;
  logic [sse_pkg::Q_W-1:0]     out_value_r;
  logic                        out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r    <= sse_pkg::TIME_STEP_RESET;
      active_order_r <= sse_pkg::ACTIVE_ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sse_pkg::CFG_TIME_STEP:    time_step_r    <= cfg_data[sse_pkg::DT_W-1:0];
        sse_pkg::CFG_ACTIVE_ORDER: active_order_r <= cfg_data[sse_pkg::ORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign order_n = sse_pkg::order_in_use(active_order_r);

  assign in_req.ready = idle;
  assign accept = in_req.valid && idle;
  assign load   = accept && (in_req.req_type == sse_pkg::REQ_LOAD);
  assign start  = accept && (in_req.req_type == sse_pkg::REQ_SAMPLE);

  // A load beyond the depth is dropped; d always lands in slot zero of its bank.
  assign cf_we    = load && ((in_req.coef_bank == sse_pkg::BANK_D)
                          || (int'(in_req.coef_index) < sse_pkg::MAX_ORDER));
  assign cf_waddr = (in_req.coef_bank == sse_pkg::BANK_D)
                  ? {sse_pkg::BANK_D, sse_pkg::IDX_W'(0)}
                  : {in_req.coef_bank, sse_pkg::IDX_W'(in_req.coef_index)};

  assign out_free = !out_valid_r || out_rsp.ready;

  sse_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .n_i        (order_n),
    .wb_done    (wb_done),
    .out_free   (out_free),
    .idle       (idle),
    .issue      (issue),
    .st_raddr_a (st_raddr_a),
    .st_raddr_b (st_raddr_b),
    .cf_raddr_a (cf_raddr_a),
    .cf_raddr_b (cf_raddr_b),
    .load_out   (load_out)
  );

  sse_state_mem u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr_a),
    .raddr_b (st_raddr_b),
    .rdata_a (st_rd_a),
    .rdata_b (st_rd_b)
  );

  sse_coef_mem u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (cf_we),
    .waddr   (cf_waddr),
    .wdata   (in_req.coef_value),
    .raddr_a (cf_raddr_a),
    .raddr_b (cf_raddr_b),
    .rdata_a (cf_rd_a),
    .rdata_b (cf_rd_b)
  );

  sse_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .issue        (issue),
    .start        (start),
    .sample_value (in_req.sample_value),
    .time_step    (time_step_r),
    .st_rd_a      (st_rd_a),
    .st_rd_b      (st_rd_b),
    .cf_rd_a      (cf_rd_a),
    .cf_rd_b      (cf_rd_b),
    .st_we        (st_we),
    .st_waddr     (st_waddr),
    .st_wdata     (st_wdata),
    .wb_done      (wb_done),
    .rsp_value    (rsp_value),
    .rsp_sat      (rsp_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= rsp_value;
      out_sat_r   <= rsp_sat;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.response_value = out_value_r;
  assign out_rsp.saturated      = out_sat_r;

endmodule
